// File: design/jbcd_pkg.sv
// jbcd_pkg: shared types, constants and helpers of the block coefficient decoder
// no dependencies; imported by every jbcd module and the top level
`default_nettype none

package jbcd_pkg;

   // block geometry
   localparam int BLOCK_COEFFS = 64;
   localparam int POS_W        = $clog2(BLOCK_COEFFS);
   localparam int MAX_BLOCKS   = 12;
   localparam int BLK_W        = 4;
   localparam int COEF_W       = 16;

   // symbol fields
   localparam int SYM_W        = 8;
   localparam int EXTRA_W      = 11;
   localparam logic [3:0] CAT_MASK = 4'hf;
   localparam logic [3:0] MAX_CAT  = 4'd11;
   localparam logic [2:0] MAX_COUNT = 3'd4;

   // component codes
   localparam logic [1:0] COMP_Y  = 2'd0;
   localparam logic [1:0] COMP_CB = 2'd1;
   localparam logic [1:0] COMP_CR = 2'd2;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_MODE         = 3'd0,
      REG_COUNT_Y      = 3'd1,
      REG_COUNT_CB     = 3'd2,
      REG_COUNT_CR     = 3'd3,
      REG_ORDER_FIRST  = 3'd4,
      REG_ORDER_SECOND = 3'd5,
      REG_ORDER_THIRD  = 3'd6
   } reg_index_type;

   // classified symbol, front to back
   typedef struct packed {
      logic [3:0]        run;
      logic              eob;
      logic [COEF_W-1:0] value;
   } sym_item_type;

   // mcu layout: component per slot and block index boundaries
   typedef struct packed {
      logic [1:0]       c0;
      logic [1:0]       c1;
      logic [1:0]       c2;
      logic [BLK_W-1:0] b0;
      logic [BLK_W-1:0] b1;
      logic [BLK_W-1:0] total;
      logic             empty;
   } layout_type;

   // back end sequencer states
   typedef enum logic {
      BACK_IDLE,
      BACK_EXPAND
   } back_state_type;

   // component of a block index within the mcu
   function automatic logic [1:0] comp_of(input layout_type l, input logic [BLK_W-1:0] idx);
      logic [1:0] c;
      if (l.empty) c = COMP_Y;
      else if (idx < l.b0) c = l.c0;
      else if (idx < l.b1) c = l.c1;
      else c = l.c2;
      return c;
   endfunction

endpackage

`default_nettype wire

// File: design/jpeg_block_coefficient_decoder.sv
// channel   dir  beat contents
// req       in   tdata: symbol, extra_bits
// rsp       out  tdata: coefficient, position, block flags, next table; tuser: component
// csr       in   apb-style writes and reads of the seven layout registers
//
// a symbol is loaded into the back end from the idle state and then expanded into
// its coefficients, one per beat while rsp is not stalled, up to the block end for
// an end-of-block; the coefficient sequencer in jbcd_back sets the rate.
// a two-entry queue lets symbol beats be taken while the back end expands runs.
// reset is synchronous and clears predictors, block walk and registers to defaults.
// under a stall the rsp register holds its beat; the queue stops the front once full.
// top level: depends on jbcd_pkg, jbcd_csr, jbcd_front, jbcd_queue, jbcd_back
`default_nettype none

module jpeg_block_coefficient_decoder (
   input  wire         clock,
   input  wire         reset,
   // symbol beats
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // symbol[7:0], extra_bits[18:8], zero[23:19]
   // coefficient beats
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // coefficient[15:0], position[21:16],
                                    // block_index[25:22], block_done[26], mcu_done[27],
                                    // overrun[28], next_is_ac[29], next_component[31:30]
   output logic [1:0]  rsp_tuser,   // component[1:0]
   output logic        rsp_tlast,   // last_result
   // configuration
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import jbcd_pkg::*;

   layout_type   layout;
   sym_item_type push_item, pop_item;
   logic         push, push_ready, pop, pop_valid;

   logic [COEF_W-1:0] coefficient;
   logic [1:0]        component, next_component;
   logic [POS_W-1:0]  position;
   logic [BLK_W-1:0]  block_index;
   logic              block_done, mcu_done, overrun, next_is_ac;

   jbcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .layout      (layout)
   );

   jbcd_front u_front (
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .symbol      (req_tdata[7:0]),
      .extra_bits  (req_tdata[18:8]),
      .push        (push),
      .item        (push_item),
      .queue_ready (push_ready)
   );

   jbcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid)
   );

   jbcd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .layout         (layout),
      .item           (pop_item),
      .item_valid     (pop_valid),
      .item_pop       (pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .coefficient    (coefficient),
      .component      (component),
      .position       (position),
      .block_index    (block_index),
      .block_done     (block_done),
      .mcu_done       (mcu_done),
      .last_result    (rsp_tlast),
      .overrun        (overrun),
      .next_is_ac     (next_is_ac),
      .next_component (next_component)
   );

   // result beat packing
   assign rsp_tdata = {next_component, next_is_ac, overrun, mcu_done, block_done,
                       block_index, position, coefficient};
   assign rsp_tuser = component;

endmodule

`default_nettype wire

// File: design/jbcd_csr.sv
// jbcd_csr: configuration registers on the apb-style port and mcu layout register
// depends on jbcd_pkg
`default_nettype none

module jbcd_csr (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_psel,
   input  wire                     csr_penable,
   input  wire                     csr_pwrite,
   input  wire  [4:0]              csr_paddr,
   input  wire  [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output jbcd_pkg::layout_type    layout
);
   import jbcd_pkg::*;

   logic       mode_ff, mode_in;
   logic [2:0] cnt_y_ff, cnt_y_in, cnt_cb_ff, cnt_cb_in, cnt_cr_ff, cnt_cr_in;
   logic [1:0] ord0_ff, ord0_in, ord1_ff, ord1_in, ord2_ff, ord2_in;
   layout_type layout_ff, layout_in;

   reg_index_type idx;
   logic          wr_en;
   logic [2:0]    n0, n1, n2;
   logic [BLK_W-1:0] sum01, sum012;

   function automatic logic [2:0] sat_count(input logic [2:0] c);
      return (c > MAX_COUNT) ? MAX_COUNT : c;
   endfunction

   assign csr_pready = 1'b1;
   assign idx   = reg_index_type'(csr_paddr[4:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_comb begin
      mode_in   = mode_ff;
      cnt_y_in  = cnt_y_ff;
      cnt_cb_in = cnt_cb_ff;
      cnt_cr_in = cnt_cr_ff;
      ord0_in   = ord0_ff;
      ord1_in   = ord1_ff;
      ord2_in   = ord2_ff;
      if (wr_en) begin
         unique case (idx)
            REG_MODE:         mode_in   = csr_pwdata[0];
            REG_COUNT_Y:      cnt_y_in  = csr_pwdata[2:0];
            REG_COUNT_CB:     cnt_cb_in = csr_pwdata[2:0];
            REG_COUNT_CR:     cnt_cr_in = csr_pwdata[2:0];
            REG_ORDER_FIRST:  ord0_in   = csr_pwdata[1:0];
            REG_ORDER_SECOND: ord1_in   = csr_pwdata[1:0];
            REG_ORDER_THIRD:  ord2_in   = csr_pwdata[1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b1;
         cnt_y_ff  <= 3'd1;
         cnt_cb_ff <= 3'd1;
         cnt_cr_ff <= 3'd1;
         ord0_ff   <= COMP_Y;
         ord1_ff   <= COMP_CB;
         ord2_ff   <= COMP_CR;
      end else begin
         mode_ff   <= mode_in;
         cnt_y_ff  <= cnt_y_in;
         cnt_cb_ff <= cnt_cb_in;
         cnt_cr_ff <= cnt_cr_in;
         ord0_ff   <= ord0_in;
         ord1_ff   <= ord1_in;
         ord2_ff   <= ord2_in;
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         REG_MODE:         csr_prdata = {31'd0, mode_ff};
         REG_COUNT_Y:      csr_prdata = {29'd0, cnt_y_ff};
         REG_COUNT_CB:     csr_prdata = {29'd0, cnt_cb_ff};
         REG_COUNT_CR:     csr_prdata = {29'd0, cnt_cr_ff};
         REG_ORDER_FIRST:  csr_prdata = {30'd0, ord0_ff};
         REG_ORDER_SECOND: csr_prdata = {30'd0, ord1_ff};
         REG_ORDER_THIRD:  csr_prdata = {30'd0, ord2_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // block count of the component in one order slot, none for an unused slot
   function automatic logic [2:0] slot_count(input logic [1:0] c, input logic [2:0] y,
                                             input logic [2:0] cb, input logic [2:0] cr);
      logic [2:0] n;
      case (c)
         COMP_Y:  n = sat_count(y);
         COMP_CB: n = sat_count(cb);
         COMP_CR: n = sat_count(cr);
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   // mcu layout: slot boundaries as running sums of block counts
   always_comb begin
      if (mode_ff) begin
         n0 = slot_count(ord0_ff, cnt_y_ff, cnt_cb_ff, cnt_cr_ff);
         n1 = slot_count(ord1_ff, cnt_y_ff, cnt_cb_ff, cnt_cr_ff);
         n2 = slot_count(ord2_ff, cnt_y_ff, cnt_cb_ff, cnt_cr_ff);
         layout_in.c0 = ord0_ff;
         layout_in.c1 = ord1_ff;
         layout_in.c2 = ord2_ff;
      end else begin
         n0 = sat_count(cnt_y_ff);
         n1 = 3'd0;
         n2 = 3'd0;
         layout_in.c0 = COMP_Y;
         layout_in.c1 = COMP_Y;
         layout_in.c2 = COMP_Y;
      end
      sum01  = BLK_W'(n0) + BLK_W'(n1);
      sum012 = sum01 + BLK_W'(n2);
      layout_in.b0    = BLK_W'(n0);
      layout_in.b1    = sum01;
      layout_in.empty = (sum012 == '0);
      layout_in.total = (sum012 == '0) ? BLK_W'(1) : sum012;
   end

   always_ff @(posedge clock) begin
      layout_ff <= layout_in;
   end

   assign layout = layout_ff;

endmodule

`default_nettype wire

// File: design/jbcd_front.sv
// jbcd_front: accepts symbol beats, clamps the category, decodes the signed value
// depends on jbcd_pkg; feeds jbcd_queue
`default_nettype none

module jbcd_front (
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [jbcd_pkg::SYM_W-1:0]   symbol,
   input  wire  [jbcd_pkg::EXTRA_W-1:0] extra_bits,
   output logic                         push,
   output jbcd_pkg::sym_item_type       item,
   input  wire                          queue_ready
);
   import jbcd_pkg::*;

   logic [3:0]         size;
   logic [EXTRA_W-1:0] full;
   logic [EXTRA_W-1:0] mag;
   logic               top_bit;

   assign req_ready = queue_ready;
   assign push      = req_valid && queue_ready;

   // category clamp and magnitude mask
   always_comb begin
      size    = (symbol[3:0] & CAT_MASK) > MAX_CAT ? MAX_CAT : (symbol[3:0] & CAT_MASK);
      full    = ~({EXTRA_W{1'b1}} << size);
      mag     = extra_bits & full;
      top_bit = (size == 4'd0) ? 1'b1 : mag[size - 4'd1];
   end

   // leading zero means negative: value minus all-ones of the category
   always_comb begin
      item.run   = symbol[7:4];
      item.eob   = (symbol == '0);
      if (size == 4'd0) item.value = '0;
      else if (!top_bit) item.value = COEF_W'(mag) - COEF_W'(full);
      else item.value = COEF_W'(mag);
   end

endmodule

`default_nettype wire

// File: design/jbcd_queue.sv
// jbcd_queue: two-entry queue of classified symbols between front and back
// depends on jbcd_pkg
`default_nettype none

module jbcd_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  jbcd_pkg::sym_item_type  push_item,
   output logic                    push_ready,
   input  wire                     pop,
   output jbcd_pkg::sym_item_type  pop_item,
   output logic                    pop_valid
);
   import jbcd_pkg::*;

   sym_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

`default_nettype wire

// File: design/jbcd_back.sv
// jbcd_back: dc prediction, zero run expansion and block walk, one coefficient a beat
// depends on jbcd_pkg; pops jbcd_queue, reads the layout from jbcd_csr
`default_nettype none

module jbcd_back (
   input  wire                          clock,
   input  wire                          reset,
   input  jbcd_pkg::layout_type         layout,
   input  jbcd_pkg::sym_item_type       item,
   input  wire                          item_valid,
   output logic                         item_pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [jbcd_pkg::COEF_W-1:0]  coefficient,
   output logic [1:0]                   component,
   output logic [jbcd_pkg::POS_W-1:0]   position,
   output logic [jbcd_pkg::BLK_W-1:0]   block_index,
   output logic                         block_done,
   output logic                         mcu_done,
   output logic                         last_result,
   output logic                         overrun,
   output logic                         next_is_ac,
   output logic [1:0]                   next_component
);
   import jbcd_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFFS - 1);

   back_state_type state_ff, state_in;

   // walk position and dc predictors
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [COEF_W-1:0] pred_ff [3];
   logic [COEF_W-1:0] pred_in [3];

   // per-symbol expansion context
   logic [POS_W-1:0]  end_ff, end_in;
   logic [COEF_W-1:0] lastc_ff, lastc_in;
   logic              over_ff, over_in;
   logic [1:0]        comp_ff, comp_in, ncomp_ff, ncomp_in;
   logic [BLK_W-1:0]  nblk_ff, nblk_in;
   logic              wrap_ff, wrap_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [COEF_W-1:0] out_coef_ff, out_coef_in;
   logic [1:0]        out_comp_ff, out_comp_in, out_ncomp_ff, out_ncomp_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic [BLK_W-1:0]  out_blk_ff, out_blk_in;
   logic              out_bdone_ff, out_bdone_in, out_mdone_ff, out_mdone_in;
   logic              out_last_ff, out_last_in, out_over_ff, out_over_in;
   logic              out_nac_ff, out_nac_in;

   logic [BLK_W-1:0]  blk_eff, nb_raw;
   logic              nb_wrap;
   logic [1:0]        comp_cur;
   logic [COEF_W-1:0] pred_cur, pred_sum;
   logic [POS_W:0]    run_sum;
   logic              emit_ok, beat_last, beat_bdone;

   // block and table lookups for a symbol about to start
   always_comb begin
      blk_eff  = (blk_ff >= layout.total) ? '0 : blk_ff;
      nb_raw   = blk_eff + BLK_W'(1);
      nb_wrap  = (nb_raw >= layout.total);
      comp_cur = comp_of(layout, blk_eff);
      case (comp_cur)
         COMP_CB: pred_cur = pred_ff[1];
         COMP_CR: pred_cur = pred_ff[2];
         default: pred_cur = pred_ff[0];
      endcase
      pred_sum = pred_cur + item.value;
      run_sum  = {1'b0, pos_ff} + (POS_W + 1)'(item.run);
   end

   assign emit_ok    = !out_valid_ff || rsp_ready;
   assign beat_last  = (pos_ff == end_ff);
   assign beat_bdone = (pos_ff == LAST_POS);

   // sequencer: load a symbol, then emit one coefficient per beat up to its end
   always_comb begin
      state_in     = state_ff;
      item_pop     = 1'b0;
      pos_in       = pos_ff;
      blk_in       = blk_ff;
      pred_in      = pred_ff;
      end_in       = end_ff;
      lastc_in     = lastc_ff;
      over_in      = over_ff;
      comp_in      = comp_ff;
      ncomp_in     = ncomp_ff;
      nblk_in      = nblk_ff;
      wrap_in      = wrap_ff;
      out_valid_in = rsp_ready ? 1'b0 : out_valid_ff;
      out_coef_in  = out_coef_ff;
      out_comp_in  = out_comp_ff;
      out_ncomp_in = out_ncomp_ff;
      out_pos_in   = out_pos_ff;
      out_blk_in   = out_blk_ff;
      out_bdone_in = out_bdone_ff;
      out_mdone_in = out_mdone_ff;
      out_last_in  = out_last_ff;
      out_over_in  = out_over_ff;
      out_nac_in   = out_nac_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               state_in = BACK_EXPAND;
               blk_in   = blk_eff;
               comp_in  = comp_cur;
               nblk_in  = nb_wrap ? '0 : nb_raw;
               wrap_in  = nb_wrap;
               ncomp_in = comp_of(layout, nb_wrap ? '0 : nb_raw);
               over_in  = 1'b0;
               if (pos_ff == '0) begin
                  // dc difference into the component predictor
                  end_in   = '0;
                  lastc_in = pred_sum;
                  case (comp_cur)
                     COMP_CB: pred_in[1] = pred_sum;
                     COMP_CR: pred_in[2] = pred_sum;
                     default: pred_in[0] = pred_sum;
                  endcase
               end else if (item.eob) begin
                  end_in   = LAST_POS;
                  lastc_in = '0;
               end else if (run_sum > (POS_W + 1)'(LAST_POS)) begin
                  // run past the block end: zeros to the end, value dropped
                  end_in   = LAST_POS;
                  lastc_in = '0;
                  over_in  = 1'b1;
               end else begin
                  end_in   = run_sum[POS_W-1:0];
                  lastc_in = item.value;
               end
            end
         end
         BACK_EXPAND: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               out_coef_in  = beat_last ? lastc_ff : '0;
               out_comp_in  = comp_ff;
               out_pos_in   = pos_ff;
               out_blk_in   = blk_ff;
               out_bdone_in = beat_bdone;
               out_mdone_in = beat_bdone && wrap_ff;
               out_last_in  = beat_last;
               out_over_in  = beat_last && over_ff;
               out_nac_in   = !beat_bdone;
               out_ncomp_in = beat_bdone ? ncomp_ff : comp_ff;
               if (beat_bdone) begin
                  pos_in = '0;
                  blk_in = nblk_ff;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
               if (beat_last) state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         pos_ff       <= '0;
         blk_ff       <= '0;
         pred_ff[0]   <= '0;
         pred_ff[1]   <= '0;
         pred_ff[2]   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         blk_ff       <= blk_in;
         pred_ff      <= pred_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // symbol context and result payload
   always_ff @(posedge clock) begin
      end_ff       <= end_in;
      lastc_ff     <= lastc_in;
      over_ff      <= over_in;
      comp_ff      <= comp_in;
      ncomp_ff     <= ncomp_in;
      nblk_ff      <= nblk_in;
      wrap_ff      <= wrap_in;
      out_coef_ff  <= out_coef_in;
      out_comp_ff  <= out_comp_in;
      out_ncomp_ff <= out_ncomp_in;
      out_pos_ff   <= out_pos_in;
      out_blk_ff   <= out_blk_in;
      out_bdone_ff <= out_bdone_in;
      out_mdone_ff <= out_mdone_in;
      out_last_ff  <= out_last_in;
      out_over_ff  <= out_over_in;
      out_nac_ff   <= out_nac_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign coefficient    = out_coef_ff;
   assign component      = out_comp_ff;
   assign position       = out_pos_ff;
   assign block_index    = out_blk_ff;
   assign block_done     = out_bdone_ff;
   assign mcu_done       = out_mdone_ff;
   assign last_result    = out_last_ff;
   assign overrun        = out_over_ff;
   assign next_is_ac     = out_nac_ff;
   assign next_component = out_ncomp_ff;

endmodule

`default_nettype wire
